// File: sv/ps2mpc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block.
// Depends on nothing; every module of the block imports it.
package ps2mpc_pkg;

    // Width of the screen size configuration registers.
    localparam int unsigned SIZE_BITS = 13;

    // Screen size after reset.
    localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;

    // Header byte fields.
    localparam logic [7:0] SYNC_MASK     = 8'h08;
    localparam logic [7:0] OVERFLOW_MASK = 8'hC0;
    localparam int unsigned X_SIGN_BIT   = 4;
    localparam int unsigned Y_SIGN_BIT   = 5;
    localparam int unsigned BUTTON_BITS  = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position of the next byte within a packet.
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_XMOVE  = 2'd1,
        POS_YMOVE  = 2'd2
    } byte_pos_t;

    // One complete, overflow-free packet in decoded form.
    typedef struct packed {
        logic [BUTTON_BITS-1:0] buttons;
        logic signed [8:0]      dx;
        logic signed [8:0]      dy;
    } packet_t;

endpackage

// File: sv/ps2mpc_assembler.sv
// Byte-to-packet assembler: tracks the byte position, resyncs on the header
// sync bit; registers overflow-free packets. Depends on ps2mpc_pkg.
module ps2mpc_assembler
    import ps2mpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_from_aux,
    output logic       pkt_valid,
    input  logic       pkt_ready,
    output packet_t    pkt
);

    byte_pos_t  pos_reg, pos_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_move_reg, x_move_next;
    logic       pkt_valid_reg;
    packet_t    pkt_reg;
    logic       take_byte;
    logic       emit;

    // The packet slot is free or drains in this cycle.
    assign s_ready   = !pkt_valid_reg || pkt_ready;
    assign take_byte = s_valid && s_ready && s_from_aux;

    always_comb begin
        pos_next    = pos_reg;
        header_next = header_reg;
        x_move_next = x_move_reg;
        emit        = 1'b0;
        if (take_byte) begin
            unique case (pos_reg)
                POS_XMOVE: begin
                    x_move_next = s_data_byte;
                    pos_next    = POS_YMOVE;
                end
                POS_YMOVE: begin
                    pos_next = POS_HEADER;
                    emit     = (header_reg & OVERFLOW_MASK) == 8'h00;
                end
                default: begin
                    // A header without the sync bit is dropped.
                    if ((s_data_byte & SYNC_MASK) != 8'h00) begin
                        header_next = s_data_byte;
                        pos_next    = POS_XMOVE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_HEADER;
            header_reg    <= 8'h00;
            x_move_reg    <= 8'h00;
            pkt_valid_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            x_move_reg <= x_move_next;
            if (emit) begin
                pkt_valid_reg <= 1'b1;
            end else if (pkt_ready) begin
                pkt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pkt_reg.buttons <= header_reg[BUTTON_BITS-1:0];
            pkt_reg.dx      <= {header_reg[X_SIGN_BIT], x_move_reg};
            pkt_reg.dy      <= {header_reg[Y_SIGN_BIT], s_data_byte};
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

// File: sv/ps2mpc_tracker.sv
// Cursor tracker: adds packet moves to the position, clamps to the screen and
// holds the result register that drives the output channel. Depends on ps2mpc_pkg.
module ps2mpc_tracker
    import ps2mpc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [SIZE_BITS-1:0]   screen_width,
    input  logic [SIZE_BITS-1:0]   screen_height,
    input  logic                   pkt_valid,
    output logic                   pkt_ready,
    input  packet_t                pkt,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_BITS-1:0]  m_cursor_x,
    output logic [COORD_BITS-1:0]  m_cursor_y,
    output logic [BUTTON_BITS-1:0] m_buttons
);

    localparam int unsigned LIM_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int unsigned SUM_BITS = COORD_BITS + 2;
    localparam logic [LIM_BITS-1:0] COORD_MAX = LIM_BITS'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(SCREEN_WIDTH_RESET / 2);
    localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(SCREEN_HEIGHT_RESET / 2);

    logic                        m_valid_reg;
    logic [COORD_BITS-1:0]       pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]       pos_y_reg, pos_y_next;
    logic [BUTTON_BITS-1:0]      buttons_reg;
    logic [COORD_BITS-1:0]       lim_x, lim_y;
    logic signed [SUM_BITS-1:0]  sum_x, sum_y;
    logic                        pkt_take;

    // Largest coordinate for a screen size: size minus one, a zero size
    // treated as one, saturated to the coordinate range.
    function automatic logic [COORD_BITS-1:0] size_limit(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] size_m1;
        logic [LIM_BITS-1:0]  ext;
        size_m1 = (size == '0) ? '0 : size - SIZE_BITS'(1);
        ext     = LIM_BITS'(size_m1);
        return (ext > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : ext[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_BITS-1:0] v,
                                                     input logic [COORD_BITS-1:0] lim);
        logic signed [SUM_BITS-1:0] lim_s;
        lim_s = $signed({2'b00, lim});
        if (v < 0) begin
            return '0;
        end else if (v > lim_s) begin
            return lim;
        end else begin
            return v[COORD_BITS-1:0];
        end
    endfunction

    assign pkt_ready = !m_valid_reg || m_ready;
    assign pkt_take  = pkt_valid && pkt_ready;

    always_comb begin
        lim_x      = size_limit(screen_width);
        lim_y      = size_limit(screen_height);
        // Screen down is positive, so the Y move is subtracted.
        sum_x      = $signed({2'b00, pos_x_reg}) + SUM_BITS'(pkt.dx);
        sum_y      = $signed({2'b00, pos_y_reg}) - SUM_BITS'(pkt.dy);
        pos_x_next = clamp(sum_x, lim_x);
        pos_y_next = clamp(sum_y, lim_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_x_reg   <= RESET_X;
            pos_y_reg   <= RESET_Y;
            buttons_reg <= '0;
        end else begin
            if (pkt_take) begin
                m_valid_reg <= 1'b1;
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                buttons_reg <= pkt.buttons;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_cursor_x = pos_x_reg;
    assign m_cursor_y = pos_y_reg;
    assign m_buttons  = buttons_reg;

endmodule

// File: sv/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet cursor block: configuration registers,
// packet assembler and cursor tracker. Depends on ps2mpc_pkg and both submodules.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_data_byte[7:0], s_from_aux
//  m_        out        m_valid / m_ready   m_cursor_x, m_cursor_y, m_buttons[2:0]
//  cfg_      in         cfg_wr_en only      cfg_index[0:0], cfg_wr_data[12:0]
//
// A byte transaction is taken in every cycle in which the packet register is
// empty or drains. After the transaction that carries the third byte of a
// packet, the packet goes first to the packet register and then to the
// result register, which raises m_valid and also holds the cursor position.
// Reset is synchronous and active low; it centers the cursor on the reset
// screen size, clears the buttons and restarts at the header byte.
// A stalled result holds the packet register; input stalls only once that
// register is also full.
module ps2_mouse_packet_cursor
    import ps2mpc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_index,
    input  logic [SIZE_BITS-1:0]   cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_from_aux,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_BITS-1:0]  m_cursor_x,
    output logic [COORD_BITS-1:0]  m_cursor_y,
    output logic [BUTTON_BITS-1:0] m_buttons
);

    logic [SIZE_BITS-1:0] screen_width_reg;
    logic [SIZE_BITS-1:0] screen_height_reg;
    logic                 pkt_valid;
    logic                 pkt_ready;
    packet_t              pkt;

    // Screen size registers. They must be written only while the block is idle,
    // so the tracker sees a settled limit for every packet; nothing enforces it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // The assembler collects header, X and Y bytes from the auxiliary port and
    // passes on only packets without an overflow bit.
    ps2mpc_assembler u_assembler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_from_aux  (s_from_aux),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .pkt         (pkt)
    );

    // The tracker applies the move, clamps to the screen and presents the
    // new position with the button state.
    ps2mpc_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .pkt_valid     (pkt_valid),
        .pkt_ready     (pkt_ready),
        .pkt           (pkt),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_x    (m_cursor_x),
        .m_cursor_y    (m_cursor_y),
        .m_buttons     (m_buttons)
    );

    // A new result only follows a packet handed to the tracker.
    a_result_from_packet: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pkt_valid && pkt_ready)
    ) else $error("result appeared without a packet transaction");

    // The cursor only moves when a packet is taken.
    a_cursor_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !(pkt_valid && pkt_ready) |=> $stable(m_cursor_x) && $stable(m_cursor_y)
    ) else $error("cursor changed without a packet transaction");

    // A waiting packet keeps its contents until the tracker takes it.
    a_packet_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt)
    ) else $error("stalled packet changed or vanished");

endmodule
